// ===== hw/rtl/stbs_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths and codes for the sorted table binary search block.
package stbs_pkg;

    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;

    // Request operation codes.
    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    // Table select codes.
    localparam logic SEL_BIG   = 1'b0;
    localparam logic SEL_SMALL = 1'b1;

    // Response status codes.
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

endpackage

// ===== hw/rtl/stbs_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and responses.
interface stbs_req_if;
    logic                             valid;
    logic                             ready;
    logic [stbs_pkg::MODE_W-1:0]      mode;
    logic                             table_sel;
    logic [stbs_pkg::KEY_W-1:0]       key;
    logic [stbs_pkg::VALUE_W-1:0]     entry_value;

    modport source (output valid, output mode, output table_sel, output key,
                    output entry_value, input ready);
    modport sink   (input valid, input mode, input table_sel, input key,
                    input entry_value, output ready);
endinterface

interface stbs_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [stbs_pkg::STATUS_W-1:0]    status;
    logic [stbs_pkg::VALUE_W-1:0]     found_value;

    modport source (output valid, output status, output found_value, input ready);
    modport sink   (input valid, input status, input found_value, output ready);
endinterface

// ===== hw/rtl/sorted_table_binary_search.sv =====
`timescale 1ns / 1ps
// Top level: two appendable key/value tables with binary search lookup.
//
// Requests arrive on the req channel and each one produces exactly one
// response on the rsp channel. A request appends a key/value pair to the
// selected table, looks a key up in it, or clears it by zeroing its count.
// Both transfer on a rising clock edge where valid and ready are high.
//
// An append, a clear or an unused mode goes from the idle state to the done
// state, then into the output register that drives rsp.valid. A lookup runs
// a binary search over the filled part of the table: each probe is a probe
// state (a registered read of the table memory), then a compare state (one
// key compare in the shared comparator). A lookup ends on a hit, or with a
// miss once the search range is empty; the number of probes P is at most
// ceil(log2(count+1)), thirteen for a full large table.
// A new request is taken once the block is back in its idle state, so it
// takes no new request before the last one has reached the output register.
// Reset clears both fill counts and the control state; table contents are
// not cleared, since a probe only reads filled entries. A stalled receiver
// holds the finished response in the output register; the block may take
// one more request meanwhile, and its result waits for the register to free.
module sorted_table_binary_search #(
    parameter int BIG_DEPTH   = 4096,
    parameter int SMALL_DEPTH = 512,
    parameter int KEY_BITS    = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    stbs_req_if.sink     req,
    stbs_rsp_if.source   rsp
);

    // Stored key width: keys compare on their low KEY_BITS bits at most.
    localparam int KB  = (KEY_BITS < stbs_pkg::KEY_W) ? KEY_BITS : stbs_pkg::KEY_W;
    localparam int BAW = $clog2(BIG_DEPTH);
    localparam int SAW = $clog2(SMALL_DEPTH);
    localparam int BCW = $clog2(BIG_DEPTH + 1);
    localparam int SCW = $clog2(SMALL_DEPTH + 1);
    localparam int CW  = (BCW > SCW) ? BCW : SCW;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PROBE = 4'b0010,
        S_CMP   = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [BCW-1:0] big_count_reg, big_count_next;
    logic [SCW-1:0] small_count_reg, small_count_next;
    logic           out_valid_reg, out_valid_next;

    // Working registers of the current request.
    logic [CW-1:0]                     lo_reg, lo_next;
    logic [CW-1:0]                     hi_reg, hi_next;
    logic [CW-1:0]                     mid_reg, mid_next;
    logic [KB-1:0]                     key_reg, key_next;
    logic                              sel_reg, sel_next;
    logic [stbs_pkg::STATUS_W-1:0]     res_status_reg, res_status_next;
    logic [stbs_pkg::VALUE_W-1:0]      res_value_reg, res_value_next;
    logic [stbs_pkg::STATUS_W-1:0]     out_status_reg, out_status_next;
    logic [stbs_pkg::VALUE_W-1:0]      out_value_reg, out_value_next;

    // Table ports.
    logic                              big_we, small_we, big_re, small_re;
    logic [KB-1:0]                     big_rkey, small_rkey, probe_key;
    logic [stbs_pkg::VALUE_W-1:0]      big_rval, small_rval, probe_val;
    logic [CW:0]                       mid_sum;
    logic [CW-1:0]                     mid;
    logic                              out_load;

    stbs_table #(.DEPTH(BIG_DEPTH), .KB(KB)) u_big (
        .clk   (clk),
        .we    (big_we),
        .waddr (big_count_reg[BAW-1:0]),
        .wkey  (req.key[KB-1:0]),
        .wval  (req.entry_value),
        .re    (big_re),
        .raddr (mid[BAW-1:0]),
        .rkey  (big_rkey),
        .rval  (big_rval)
    );

    stbs_table #(.DEPTH(SMALL_DEPTH), .KB(KB)) u_small (
        .clk   (clk),
        .we    (small_we),
        .waddr (small_count_reg[SAW-1:0]),
        .wkey  (req.key[KB-1:0]),
        .wval  (req.entry_value),
        .re    (small_re),
        .raddr (mid[SAW-1:0]),
        .rkey  (small_rkey),
        .rval  (small_rval)
    );

    // Midpoint of the open range; it always lies below hi, so it fits the
    // address of whichever table is selected.
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = mid_sum[CW:1];
    assign probe_key = sel_reg ? small_rkey : big_rkey;
    assign probe_val = sel_reg ? small_rval : big_rval;

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.found_value = out_value_reg;

    always_comb
    begin
        state_next       = state_reg;
        big_count_next   = big_count_reg;
        small_count_next = small_count_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        mid_next         = mid_reg;
        key_next         = key_reg;
        sel_next         = sel_reg;
        res_status_next  = res_status_reg;
        res_value_next   = res_value_reg;
        big_we           = 1'b0;
        small_we         = 1'b0;
        big_re           = 1'b0;
        small_re         = 1'b0;
        out_load         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    key_next        = req.key[KB-1:0];
                    sel_next        = req.table_sel;
                    res_status_next = stbs_pkg::ST_OK;
                    res_value_next  = '0;
                    state_next      = S_DONE;
                    case (req.mode)
                        stbs_pkg::MODE_APPEND:
                        begin
                            if (req.table_sel == stbs_pkg::SEL_SMALL)
                            begin
                                if (small_count_reg < SCW'(SMALL_DEPTH))
                                begin
                                    small_we         = 1'b1;
                                    small_count_next = small_count_reg + SCW'(1);
                                end
                                else
                                begin
                                    res_status_next = stbs_pkg::ST_FULL;
                                end
                            end
                            else
                            begin
                                if (big_count_reg < BCW'(BIG_DEPTH))
                                begin
                                    big_we         = 1'b1;
                                    big_count_next = big_count_reg + BCW'(1);
                                end
                                else
                                begin
                                    res_status_next = stbs_pkg::ST_FULL;
                                end
                            end
                        end
                        stbs_pkg::MODE_LOOKUP:
                        begin
                            lo_next    = '0;
                            hi_next    = (req.table_sel == stbs_pkg::SEL_SMALL) ?
                                         CW'(small_count_reg) : CW'(big_count_reg);
                            state_next = S_PROBE;
                        end
                        stbs_pkg::MODE_CLEAR:
                        begin
                            if (req.table_sel == stbs_pkg::SEL_SMALL)
                            begin
                                small_count_next = '0;
                            end
                            else
                            begin
                                big_count_next = '0;
                            end
                        end
                        default:
                        begin
                            res_status_next = stbs_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_PROBE:
            begin
                if (lo_reg == hi_reg)
                begin
                    res_status_next = stbs_pkg::ST_MISS;
                    state_next      = S_DONE;
                end
                else
                begin
                    mid_next   = mid;
                    big_re     = (sel_reg == stbs_pkg::SEL_BIG);
                    small_re   = (sel_reg == stbs_pkg::SEL_SMALL);
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                // The one comparator decides the next narrowing step.
                if (probe_key == key_reg)
                begin
                    res_status_next = stbs_pkg::ST_OK;
                    res_value_next  = probe_val;
                    state_next      = S_DONE;
                end
                else
                begin
                    if (probe_key < key_reg)
                    begin
                        lo_next = mid_reg + CW'(1);
                    end
                    else
                    begin
                        hi_next = mid_reg;
                    end
                    state_next = S_PROBE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_value_next  = res_value_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            big_count_reg   <= '0;
            small_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            big_count_reg   <= big_count_next;
            small_count_reg <= small_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        key_reg        <= key_next;
        sel_reg        <= sel_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
    end

    // The search range never inverts while a lookup runs.
    a_range_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE || state_reg == S_CMP) |-> (lo_reg <= hi_reg))
        else $error("search range inverted");

    // A compared entry always lies inside the filled part of the table.
    a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (mid_reg >= lo_reg && mid_reg < hi_reg))
        else $error("probe outside search range");

    // Fill counts never pass their table depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (big_count_reg <= BCW'(BIG_DEPTH)) && (small_count_reg <= SCW'(SMALL_DEPTH)))
        else $error("fill count beyond table depth");

    // A finished result is presented on the next cycle.
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && (!out_valid_reg || rsp.ready)) |=>
        (out_valid_reg && state_reg == S_IDLE))
        else $error("finished result not presented");

endmodule

// ===== hw/rtl/stbs_table.sv =====
`timescale 1ns / 1ps
// One key/value table memory with a write port and a registered read port.
module stbs_table #(
    parameter int DEPTH = 4096,
    parameter int KB    = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic                           clk,
    input  logic                           we,
    input  logic [AW-1:0]                  waddr,
    input  logic [KB-1:0]                  wkey,
    input  logic [stbs_pkg::VALUE_W-1:0]   wval,
    input  logic                           re,
    input  logic [AW-1:0]                  raddr,
    output logic [KB-1:0]                  rkey,
    output logic [stbs_pkg::VALUE_W-1:0]   rval
);

    localparam int WW = KB + stbs_pkg::VALUE_W;

    logic [WW-1:0] mem [DEPTH];
    logic [WW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wkey, wval};
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rkey = rdata_reg[WW-1:stbs_pkg::VALUE_W];
    assign rval = rdata_reg[stbs_pkg::VALUE_W-1:0];

endmodule

// ===== bench/tb_sorted_table_binary_search.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the sorted table binary search block.
module tb_sorted_table_binary_search;

    localparam int BIG_DEPTH   = 4096;
    localparam int SMALL_DEPTH = 512;
    localparam int KEY_BITS    = 32;

    typedef logic [stbs_pkg::MODE_W-1:0] mode_t;

    // The block treats mode 3 as a no-op that still answers.
    localparam mode_t MODE_UNUSED = 2'd3;

    localparam int unsigned RANDOM_ITEMS   = 320;
    localparam int unsigned HOLDOFF_AT     = 300;
    localparam int unsigned HOLDOFF_CYCLES = 100;
    localparam int unsigned TAIL_CYCLES    = 40;
    localparam int unsigned QUIET_LIMIT    = 2000;

    // A request as the driver sends it. The gap is the number of idle cycles
    // spent before it is offered; hold makes the driver wait until every
    // earlier request has been answered.
    typedef struct {
        logic [stbs_pkg::MODE_W-1:0]  mode;
        logic                         table_sel;
        logic [stbs_pkg::KEY_W-1:0]   key;
        logic [stbs_pkg::VALUE_W-1:0] entry_value;
        int unsigned                  gap;
        bit                           hold;
    } table_request_t;

    typedef struct packed {
        logic [stbs_pkg::STATUS_W-1:0] status;
        logic [stbs_pkg::VALUE_W-1:0]  found_value;
    } table_answer_t;

    logic clk;
    logic rst_n;

    stbs_req_if req_ch ();
    stbs_rsp_if rsp_ch ();

    sorted_table_binary_search #(
        .BIG_DEPTH   (BIG_DEPTH),
        .SMALL_DEPTH (SMALL_DEPTH),
        .KEY_BITS    (KEY_BITS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Requests waiting to be sent, and answers predicted for accepted ones.
    table_request_t request_queue [$];
    table_answer_t  answer_queue [$];

    int unsigned n_sent;
    int unsigned n_got;
    int unsigned errors;

    // Predictor state: the contents and fill count of both tables, indexed by
    // the table select code. The small table uses only its first entries.
    logic [stbs_pkg::KEY_W-1:0]   table_keys   [2][BIG_DEPTH];
    logic [stbs_pkg::VALUE_W-1:0] table_values [2][BIG_DEPTH];
    int unsigned                  table_fill   [2];

    int unsigned n_appends;
    int unsigned n_full;
    int unsigned n_lookups;
    int unsigned n_hits;
    int unsigned n_clears;

    // Stimulus planning keeps its own view of what has been appended, so
    // that lookups can aim at keys which are really present.
    logic [stbs_pkg::KEY_W-1:0] plan_keys [2][BIG_DEPTH];
    int unsigned                plan_fill [2];
    int unsigned                n_queued;
    int unsigned                gap_cap;
    bit                         hold_next;

    function automatic int unsigned table_depth(input logic sel);
        return (sel == stbs_pkg::SEL_SMALL) ? SMALL_DEPTH : BIG_DEPTH;
    endfunction

    // Applies one accepted request to the predictor state and returns the
    // answer the block must give for it.
    function automatic table_answer_t predict_answer(
        input logic [stbs_pkg::MODE_W-1:0]  mode,
        input logic                         sel,
        input logic [stbs_pkg::KEY_W-1:0]   key,
        input logic [stbs_pkg::VALUE_W-1:0] entry_value
    );
        table_answer_t ans;
        int unsigned   t;
        int unsigned   lo;
        int unsigned   hi;
        int unsigned   mid;
        bit            hit;

        ans.status      = stbs_pkg::ST_OK;
        ans.found_value = '0;
        t = (sel == stbs_pkg::SEL_SMALL) ? 1 : 0;
        case (mode)
            stbs_pkg::MODE_APPEND:
            begin
                if (table_fill[t] < table_depth(sel))
                begin
                    table_keys[t][table_fill[t]]   = key;
                    table_values[t][table_fill[t]] = entry_value;
                    table_fill[t]++;
                    n_appends++;
                end
                else
                begin
                    ans.status = stbs_pkg::ST_FULL;
                    n_full++;
                end
            end
            stbs_pkg::MODE_LOOKUP:
            begin
                // Plain binary search over the filled part; keys that were
                // appended out of order just steer the probes elsewhere.
                lo  = 0;
                hi  = table_fill[t];
                hit = 1'b0;
                n_lookups++;
                while (lo != hi && !hit)
                begin
                    mid = lo + (hi - lo) / 2;
                    if (table_keys[t][mid] == key)
                    begin
                        hit             = 1'b1;
                        ans.found_value = table_values[t][mid];
                    end
                    else if (table_keys[t][mid] < key)
                        lo = mid + 1;
                    else
                        hi = mid;
                end
                if (hit)
                    n_hits++;
                else
                    ans.status = stbs_pkg::ST_MISS;
            end
            stbs_pkg::MODE_CLEAR:
            begin
                table_fill[t] = 0;
                n_clears++;
            end
            default:
            begin
            end
        endcase
        return ans;
    endfunction

    task automatic queue_request(
        input logic [stbs_pkg::MODE_W-1:0]  mode,
        input logic                         sel,
        input logic [stbs_pkg::KEY_W-1:0]   key,
        input logic [stbs_pkg::VALUE_W-1:0] entry_value
    );
        table_request_t item;
        int unsigned    t;

        item.mode        = mode;
        item.table_sel   = sel;
        item.key         = key;
        item.entry_value = entry_value;
        item.gap         = (gap_cap == 0) ? 0 : $urandom_range(0, gap_cap);
        item.hold        = hold_next;
        hold_next        = 1'b0;
        request_queue.push_back(item);
        n_queued++;

        t = (sel == stbs_pkg::SEL_SMALL) ? 1 : 0;
        if (mode == stbs_pkg::MODE_APPEND && plan_fill[t] < table_depth(sel))
        begin
            plan_keys[t][plan_fill[t]] = key;
            plan_fill[t]++;
        end
        else if (mode == stbs_pkg::MODE_CLEAR)
            plan_fill[t] = 0;
    endtask

    // Appends a run of ascending keys after the current top key of a table.
    // A table whose top key leaves too little headroom is cleared first.
    task automatic append_run(input logic sel, input int unsigned n,
                              input int unsigned step_max);
        logic [stbs_pkg::KEY_W-1:0] k;
        int unsigned                t;

        t = (sel == stbs_pkg::SEL_SMALL) ? 1 : 0;
        if (plan_fill[t] != 0 && plan_keys[t][plan_fill[t]-1] > 32'hC000_0000)
            queue_request(stbs_pkg::MODE_CLEAR, sel, $urandom(), $urandom());
        if (plan_fill[t] == 0)
            k = $urandom_range(0, 255);
        else
            k = plan_keys[t][plan_fill[t]-1];
        repeat (n)
        begin
            k = k + $urandom_range(1, step_max);
            queue_request(stbs_pkg::MODE_APPEND, sel, k, $urandom());
        end
    endtask

    // Lookups that mostly hit stored keys, some just beside them, a few
    // anywhere.
    task automatic lookup_mix(input logic sel, input int unsigned n);
        int unsigned                t;
        int unsigned                pick;
        logic [stbs_pkg::KEY_W-1:0] k;

        t = (sel == stbs_pkg::SEL_SMALL) ? 1 : 0;
        repeat (n)
        begin
            pick = $urandom_range(0, 9);
            if (plan_fill[t] != 0 && pick < 6)
                k = plan_keys[t][$urandom_range(0, plan_fill[t] - 1)];
            else if (plan_fill[t] != 0 && pick < 8)
                k = plan_keys[t][$urandom_range(0, plan_fill[t] - 1)] + 1;
            else
                k = $urandom();
            queue_request(stbs_pkg::MODE_LOOKUP, sel, k, $urandom());
        end
    endtask

    // Driver: offers the head of the request queue after its gap and
    // predicts the answer for every request the block accepts.
    always @(posedge clk or negedge rst_n)
    begin : request_side
        bit             accepted;
        int unsigned    sent_now;
        table_request_t item;
        int unsigned    idle_cnt;

        if (!rst_n)
        begin
            req_ch.valid       <= 1'b0;
            req_ch.mode        <= stbs_pkg::MODE_APPEND;
            req_ch.table_sel   <= stbs_pkg::SEL_BIG;
            req_ch.key         <= '0;
            req_ch.entry_value <= '0;
            n_sent             <= 0;
            idle_cnt = 0;
        end
        else
        begin
            accepted = req_ch.valid && req_ch.ready;
            sent_now = n_sent + (accepted ? 1 : 0);
            if (accepted)
            begin
                answer_queue.push_back(predict_answer(req_ch.mode, req_ch.table_sel,
                                                      req_ch.key, req_ch.entry_value));
                n_sent <= sent_now;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (request_queue.size() == 0)
                    req_ch.valid <= 1'b0;
                else if (request_queue[0].hold && sent_now != n_got)
                    req_ch.valid <= 1'b0;
                else if (idle_cnt < request_queue[0].gap)
                begin
                    idle_cnt++;
                    req_ch.valid <= 1'b0;
                end
                else
                begin
                    item = request_queue.pop_front();
                    idle_cnt = 0;
                    req_ch.valid       <= 1'b1;
                    req_ch.mode        <= item.mode;
                    req_ch.table_sel   <= item.table_sel;
                    req_ch.key         <= item.key;
                    req_ch.entry_value <= item.entry_value;
                end
            end
        end
    end

    // Monitor: checks every answer against the oldest prediction and
    // throttles ready. Once, it holds ready low for a long stretch while the
    // driver keeps offering, so the block fills up and stalls its input.
    always @(posedge clk or negedge rst_n)
    begin : answer_side
        table_answer_t want;
        int unsigned   w;
        int unsigned   rsp_wait;
        bit            holdoff_done;

        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            n_got        <= 0;
            rsp_wait     = 0;
            holdoff_done = 1'b0;
        end
        else if (rsp_ch.valid && rsp_ch.ready)
        begin
            if (answer_queue.size() == 0)
            begin
                errors++;
                $display("%0t: answer with nothing expected: status %0d value %h",
                         $time, rsp_ch.status, rsp_ch.found_value);
            end
            else
            begin
                want = answer_queue.pop_front();
                if (rsp_ch.status !== want.status)
                begin
                    errors++;
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, rsp_ch.status);
                end
                if (rsp_ch.found_value !== want.found_value)
                begin
                    errors++;
                    $display("%0t: found_value mismatch: expected %h, actual %h",
                             $time, want.found_value, rsp_ch.found_value);
                end
            end
            n_got <= n_got + 1;
            if (!holdoff_done && n_got + 1 >= HOLDOFF_AT && req_ch.valid)
            begin
                holdoff_done = 1'b1;
                rsp_wait     = HOLDOFF_CYCLES;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                // Every fourth block of 128 answers is taken without stalls.
                w = (n_got[8:7] == 2'b01) ? 0 : $urandom_range(0, 5);
                rsp_wait = w;
                rsp_ch.ready <= (w == 0);
            end
        end
        else if (rsp_wait != 0)
        begin
            rsp_wait--;
            rsp_ch.ready <= (rsp_wait == 0);
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    // Watchdog: ends the run when neither channel moves for too long.
    always @(posedge clk)
    begin : watchdog
        int unsigned quiet;

        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("%0t: no request or answer moved for %0d cycles", $time, quiet);
            $display("tb_sorted_table_binary_search NOT OK");
            $finish;
        end
    end

    initial
    begin : main
        int unsigned random_end;
        int unsigned choice;
        logic        sel;

        // Every input of the block is known from time zero.
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.mode        = stbs_pkg::MODE_APPEND;
        req_ch.table_sel   = stbs_pkg::SEL_BIG;
        req_ch.key         = '0;
        req_ch.entry_value = '0;
        rsp_ch.ready       = 1'b0;
        errors    = 0;
        n_queued  = 0;
        hold_next = 1'b0;
        gap_cap   = 5;
        plan_fill[0] = 0;
        plan_fill[1] = 0;
        table_fill[0] = 0;
        table_fill[1] = 0;
        n_appends = 0;
        n_full    = 0;
        n_lookups = 0;
        n_hits    = 0;
        n_clears  = 0;

        // Directed part: lookups in empty tables, extreme keys and values,
        // a hit at both ends and a miss in between, keys appended out of
        // order, the unused mode, and lookups right after a clear.
        queue_request(stbs_pkg::MODE_LOOKUP, stbs_pkg::SEL_BIG,   32'h0000_0000, 32'h0000_0000);
        queue_request(stbs_pkg::MODE_LOOKUP, stbs_pkg::SEL_SMALL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(stbs_pkg::MODE_APPEND, stbs_pkg::SEL_BIG,   32'h0000_0000, 32'hFFFF_FFFF);
        queue_request(stbs_pkg::MODE_APPEND, stbs_pkg::SEL_BIG,   32'h7FFF_FFFF, 32'h1234_5678);
        queue_request(stbs_pkg::MODE_APPEND, stbs_pkg::SEL_BIG,   32'hFFFF_FFFF, 32'h0000_0000);
        queue_request(stbs_pkg::MODE_LOOKUP, stbs_pkg::SEL_BIG,   32'h0000_0000, 32'hFFFF_FFFF);
        queue_request(stbs_pkg::MODE_LOOKUP, stbs_pkg::SEL_BIG,   32'hFFFF_FFFF, 32'h0000_0000);
        queue_request(stbs_pkg::MODE_LOOKUP, stbs_pkg::SEL_BIG,   32'h7FFF_FFFF, 32'h0000_0000);
        queue_request(stbs_pkg::MODE_LOOKUP, stbs_pkg::SEL_BIG,   32'h8000_0000, 32'h0000_0000);
        queue_request(stbs_pkg::MODE_APPEND, stbs_pkg::SEL_SMALL, 32'h8000_0000, 32'h5555_5555);
        queue_request(stbs_pkg::MODE_APPEND, stbs_pkg::SEL_SMALL, 32'h0000_0010, 32'hAAAA_AAAA);
        queue_request(stbs_pkg::MODE_APPEND, stbs_pkg::SEL_SMALL, 32'h0000_0005, 32'h0000_0001);
        queue_request(stbs_pkg::MODE_LOOKUP, stbs_pkg::SEL_SMALL, 32'h0000_0005, 32'h0000_0000);
        queue_request(stbs_pkg::MODE_LOOKUP, stbs_pkg::SEL_SMALL, 32'h0000_0010, 32'h0000_0000);
        queue_request(stbs_pkg::MODE_LOOKUP, stbs_pkg::SEL_SMALL, 32'h8000_0000, 32'h0000_0000);
        queue_request(MODE_UNUSED,           stbs_pkg::SEL_BIG,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(MODE_UNUSED,           stbs_pkg::SEL_SMALL, 32'h0000_0000, 32'h0000_0000);
        queue_request(stbs_pkg::MODE_CLEAR,  stbs_pkg::SEL_BIG,   32'h0000_0000, 32'h0000_0000);
        queue_request(stbs_pkg::MODE_LOOKUP, stbs_pkg::SEL_BIG,   32'h0000_0000, 32'h0000_0000);
        queue_request(stbs_pkg::MODE_CLEAR,  stbs_pkg::SEL_SMALL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(stbs_pkg::MODE_LOOKUP, stbs_pkg::SEL_SMALL, 32'h0000_0005, 32'h0000_0000);
        queue_request(stbs_pkg::MODE_APPEND, stbs_pkg::SEL_SMALL, 32'h0000_0003, 32'hDEAD_BEEF);
        queue_request(stbs_pkg::MODE_LOOKUP, stbs_pkg::SEL_SMALL, 32'h0000_0003, 32'h0000_0000);

        // Random part: mostly runs of ascending appends followed by lookups,
        // with some noise in between. Now and then the driver waits for the
        // block to drain before the next sequence.
        hold_next  = 1'b1;
        random_end = n_queued + RANDOM_ITEMS;
        while (n_queued < random_end)
        begin
            sel     = 1'($urandom_range(0, 1));
            gap_cap = ($urandom_range(0, 3) == 0) ? 0 : 5;
            if ($urandom_range(0, 9) == 0)
                hold_next = 1'b1;
            choice = $urandom_range(0, 9);
            if (choice < 7)
            begin
                if ($urandom_range(0, 3) == 0)
                    queue_request(stbs_pkg::MODE_CLEAR, sel, $urandom(), $urandom());
                append_run(sel, $urandom_range(1, 40), 1 << 20);
                lookup_mix(sel, $urandom_range(1, 20));
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                    queue_request(mode_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                  $urandom(), $urandom());
            end
        end

        // Fill the small table to capacity, push appends past the end, and
        // search it full so that lookups take their longest probe chains.
        gap_cap   = 2;
        hold_next = 1'b1;
        queue_request(stbs_pkg::MODE_CLEAR, stbs_pkg::SEL_SMALL, $urandom(), $urandom());
        append_run(stbs_pkg::SEL_SMALL, SMALL_DEPTH, 1 << 22);
        queue_request(stbs_pkg::MODE_APPEND, stbs_pkg::SEL_SMALL, $urandom(), $urandom());
        queue_request(stbs_pkg::MODE_APPEND, stbs_pkg::SEL_SMALL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(stbs_pkg::MODE_LOOKUP, stbs_pkg::SEL_SMALL, plan_keys[1][0], $urandom());
        queue_request(stbs_pkg::MODE_LOOKUP, stbs_pkg::SEL_SMALL,
                      plan_keys[1][SMALL_DEPTH-1], $urandom());
        queue_request(stbs_pkg::MODE_LOOKUP, stbs_pkg::SEL_SMALL, 32'hFFFF_FFFF, $urandom());
        lookup_mix(stbs_pkg::SEL_SMALL, 30);

        // A last look at the large table, then clear it and search it empty.
        hold_next = 1'b1;
        lookup_mix(stbs_pkg::SEL_BIG, 10);
        gap_cap = 5;
        queue_request(stbs_pkg::MODE_CLEAR, stbs_pkg::SEL_BIG, $urandom(), $urandom());
        queue_request(stbs_pkg::MODE_LOOKUP, stbs_pkg::SEL_BIG, $urandom(), $urandom());

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every request is sent and answered, then let the block
        // sit for a little longer than its slowest lookup.
        while (request_queue.size() != 0 || req_ch.valid || n_sent != n_got)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (answer_queue.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected answers never arrived", $time, answer_queue.size());
        end

        $display("Sent %0d requests: %0d appends stored, %0d refused on a full table, %0d clears.",
                 n_sent, n_appends, n_full, n_clears);
        $display("Ran %0d lookups (%0d hits), with the small table filled to capacity; %0d errors.",
                 n_lookups, n_hits, errors);
        if (errors == 0)
            $display("tb_sorted_table_binary_search OK");
        else
            $display("tb_sorted_table_binary_search NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/stbs_pkg.sv
hw/rtl/stbs_if.sv
hw/rtl/stbs_table.sv
hw/rtl/sorted_table_binary_search.sv
bench/tb_sorted_table_binary_search.sv
